// ----- hdl/lfx_pkg.sv -----
// ----------------------------------------------------------------------------
// lfx_pkg
// Shared types, constants and elaboration-time helpers for the rangefinder
// record framer and point converter.
// ----------------------------------------------------------------------------
package lfx_pkg;

	localparam int unsigned REC_HELD   = 6;
	localparam int unsigned FULL_TURN  = 360;
	localparam int unsigned HALF_TURN  = 180;
	localparam int unsigned QUARTER    = 90;
	localparam int unsigned ANG_SHIFT  = 4;
	localparam int unsigned MAC_HI_SH  = 16;
	localparam int unsigned OUT_W      = 17;
	localparam int unsigned TBL_DEPTH  = 91;

	localparam logic [8:0] CHK_MOD = 9'd255;

	localparam logic [1:0] CFG_ROTATE_STEP = 2'd0;
	localparam logic [1:0] CFG_POINTS      = 2'd1;

	localparam logic [8:0]  ROT_RESET = 9'd10;
	localparam logic [15:0] PPP_RESET = 16'd100;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SA,
		ST_SD,
		ST_CZ,
		ST_XL,
		ST_XH,
		ST_YL,
		ST_YH,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MAC_NONE,
		MAC_LOAD,
		MAC_ADDHI
	} mac_op_t;

	typedef struct packed {
		logic        match;
		logic [15:0] dist_cm;
		logic [8:0]  ang;
		logic        resync;
	} rec_t;

	// angle in whole degrees (0..4095) reduced to 0..359
	function automatic logic [8:0] ang_mod360(input logic [11:0] v);
		logic [11:0] r;
		r = v;
		if (r >= 12'd2880) r = r - 12'd2880;
		if (r >= 12'd1440) r = r - 12'd1440;
		if (r >= 12'd720)  r = r - 12'd720;
		if (r >= 12'd360)  r = r - 12'd360;
		return r[8:0];
	endfunction

	// sin(k deg) in Q1.frac, evaluated at elaboration only
	function automatic logic [31:0] sin_q(input int unsigned k, input int unsigned frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned res;
		x    = (longint'(k) * PI_Q30 + 64'd90) / HALF_TURN;
		x2   = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 10; n++) begin
			term = (term * x2) >> 30;
			// divide by (2n)(2n+1)
			case (n)
				1:       term = term / 64'd6;
				2:       term = term / 64'd20;
				3:       term = term / 64'd42;
				4:       term = term / 64'd72;
				5:       term = term / 64'd110;
				6:       term = term / 64'd156;
				7:       term = term / 64'd210;
				8:       term = term / 64'd272;
				9:       term = term / 64'd342;
				default: term = term / 64'd420;
			endcase
			if (n % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
		res = (longint'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
		return res[31:0];
	endfunction

endpackage

// ----- hdl/lfx_framer.sv -----
// ----------------------------------------------------------------------------
// lfx_framer
// Collects received bytes into 7-byte records, checks the mod-255 checksum
// and slides the window one byte at a time while hunting for alignment.
// ----------------------------------------------------------------------------
module lfx_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output lfx_pkg::rec_t     rec
);

	logic [7:0]  win_q [lfx_pkg::REC_HELD];
	logic [2:0]  fill_q;
	logic        hunt_q;
	logic [10:0] sum;
	logic [8:0]  fold;
	logic [7:0]  chk;
	logic        full;
	logic        hit;

	always_comb begin
		sum = '0;
		for (int i = 0; i < lfx_pkg::REC_HELD; i++) begin
			sum = sum + 11'(win_q[i]);
		end
		fold = 9'(sum[10:8]) + 9'(sum[7:0]);
		if (fold >= lfx_pkg::CHK_MOD) begin
			fold = fold - lfx_pkg::CHK_MOD;
		end
		chk  = fold[7:0];
		full = (fill_q == 3'(lfx_pkg::REC_HELD));
		hit  = full && (chk == rx_byte);
	end

	assign rec.match   = take && hit;
	assign rec.dist_cm = {win_q[4], win_q[3]};
	assign rec.ang     = lfx_pkg::ang_mod360(12'({win_q[2], win_q[1]} >> lfx_pkg::ANG_SHIFT));
	assign rec.resync  = hunt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hunt_q <= 1'b0;
		end else if (take) begin
			if (!full) begin
				fill_q <= fill_q + 3'd1;
			end else if (hit) begin
				fill_q <= '0;
				hunt_q <= 1'b0;
			end else begin
				hunt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (!full) begin
				win_q[fill_q] <= rx_byte;
			end else if (!hit) begin
				for (int i = 0; i < lfx_pkg::REC_HELD - 1; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[lfx_pkg::REC_HELD - 1] <= rx_byte;
			end
		end
	end

endmodule

// ----- hdl/lfx_trig.sv -----
// ----------------------------------------------------------------------------
// lfx_trig
// Per-degree sine lookup with quadrant folding; an optional quarter-turn
// offset yields the cosine.
// ----------------------------------------------------------------------------
module lfx_trig #(
	parameter int unsigned F  = 14,
	parameter int unsigned TW = F + 1
) (
	input  logic [8:0]    ang,
	input  logic          add90,
	output logic [TW-1:0] mag,
	output logic          neg
);

	logic [TW-1:0] tbl [lfx_pkg::TBL_DEPTH];
	logic [9:0]    s;
	logic [8:0]    a;
	logic [6:0]    idx;

	for (genvar k = 0; k < lfx_pkg::TBL_DEPTH; k++) begin : g_tbl
		localparam logic [TW-1:0] VAL = TW'(lfx_pkg::sin_q(k, F));
		assign tbl[k] = VAL;
	end

	always_comb begin
		s = {1'b0, ang} + (add90 ? 10'(lfx_pkg::QUARTER) : 10'd0);
		if (s >= 10'(lfx_pkg::FULL_TURN)) begin
			s = s - 10'(lfx_pkg::FULL_TURN);
		end
		a   = s[8:0];
		neg = (a > 9'(lfx_pkg::HALF_TURN));
		if (a <= 9'(lfx_pkg::QUARTER)) begin
			idx = a[6:0];
		end else if (a <= 9'(lfx_pkg::HALF_TURN)) begin
			idx = 7'(9'(lfx_pkg::HALF_TURN) - a);
		end else if (a <= 9'(lfx_pkg::HALF_TURN + lfx_pkg::QUARTER)) begin
			idx = 7'(a - 9'(lfx_pkg::HALF_TURN));
		end else begin
			idx = 7'(9'(lfx_pkg::FULL_TURN) - a);
		end
		mag = tbl[idx];
	end

endmodule

// ----- hdl/lfx_mac.sv -----
// ----------------------------------------------------------------------------
// lfx_mac
// Shared multiplier with accumulator: load a product, or add a product
// shifted up by 16 bits for the upper partial of a wide operand.
// ----------------------------------------------------------------------------
module lfx_mac #(
	parameter int unsigned TW = 15,
	parameter int unsigned MW = 16,
	parameter int unsigned AW = 46
) (
	input  logic                 clk,
	input  lfx_pkg::mac_op_t     op,
	input  logic [TW-1:0]        a,
	input  logic [MW-1:0]        b,
	output logic [AW-1:0]        acc
);

	logic [TW+MW-1:0] prod;
	logic [AW-1:0]    acc_q;

	assign prod = a * b;
	assign acc  = acc_q;

	always_ff @(posedge clk) begin
		case (op)
			lfx_pkg::MAC_LOAD:  acc_q <= AW'(prod);
			lfx_pkg::MAC_ADDHI: acc_q <= acc_q + (AW'(prod) << lfx_pkg::MAC_HI_SH);
			default: ;
		endcase
	end

endmodule

// ----- hdl/lidar_frame_sync_to_xyz_top.sv -----
// Output: a valid record runs SA, SD, CZ, XL, XH, YL, YH, OUT; out_valid rises once OUT loads.
// Throughput: one byte per cycle while in_stall is low; after a valid record in_stall stays high
// until ST_OUT loads the point, once any held point is taken; x and y take two MAC passes each.
// Each point takes 8 steps of the shared multiplier/trig sequencer.
// Reset: asynchronous, active low; framer aligned and empty, plane 0, registers to defaults.
// ----------------------------------------------------------------------------
// lidar_frame_sync_to_xyz_top
// Frames rangefinder bytes into records and converts each valid record into
// an x/y/z point using a shared trig lookup and multiply-accumulate unit.
// ----------------------------------------------------------------------------
module lidar_frame_sync_to_xyz_top #(
	parameter int unsigned TRIG_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] x_cm,
	output logic signed [16:0] y_cm,
	output logic signed [16:0] z_cm,
	output logic [8:0]         plane_deg,
	output logic               resynced,
	output logic               plane_end,
	output logic               scan_end,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int unsigned F    = TRIG_FRAC_BITS;
	localparam int unsigned TW   = F + 1;
	localparam int unsigned MW   = (TW > 16) ? TW : 16;
	localparam int unsigned AW   = 2 * TW + 16;
	localparam int unsigned PSDW = TW + 16;
	localparam logic [AW-1:0] HALF_F  = AW'(1) << (F - 1);
	localparam logic [AW-1:0] HALF_2F = AW'(1) << (2 * F - 1);

	lfx_pkg::state_t  state_q, state_d;
	lfx_pkg::rec_t    rec;
	lfx_pkg::mac_op_t mac_op;

	logic          take;
	logic [8:0]    rot_q;
	logic [15:0]   ppp_q;
	logic [15:0]   pcnt_q;
	logic [8:0]    plane_q;
	logic          out_valid_q;
	logic          out_load;

	logic [15:0]   dist_q;
	logic [8:0]    ang_q;
	logic          resync_q;
	logic [TW-1:0] t_mag_q;
	logic          t_neg_q;
	logic          sa_neg_q;
	logic          neg_q;
	logic [PSDW-1:0] psd_q;
	logic [16:0]   z_q;
	logic [16:0]   x_q;

	logic [8:0]    trig_ang;
	logic          trig_add90;
	logic          t_load;
	logic [TW-1:0] trig_mag;
	logic          trig_neg;
	logic [MW-1:0] mac_b;
	logic [AW-1:0] acc;

	logic          is_z;
	logic [AW-1:0] rnd_sum;
	logic [16:0]   rnd_mag;
	logic [16:0]   rnd_val;

	logic [16:0]   cnt_next;
	logic [9:0]    plane_next;
	logic          pend;
	logic          send;

	assign take      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	lfx_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.rec     (rec)
	);

	lfx_trig #(
		.F  (F),
		.TW (TW)
	) u_trig (
		.ang   (trig_ang),
		.add90 (trig_add90),
		.mag   (trig_mag),
		.neg   (trig_neg)
	);

	lfx_mac #(
		.TW (TW),
		.MW (MW),
		.AW (AW)
	) u_mac (
		.clk (clk),
		.op  (mac_op),
		.a   (t_mag_q),
		.b   (mac_b),
		.acc (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		mac_op     = lfx_pkg::MAC_NONE;
		mac_b      = MW'(dist_q);
		trig_ang   = ang_q;
		trig_add90 = 1'b0;
		t_load     = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			lfx_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (rec.match) state_d = lfx_pkg::ST_SA;
			end
			lfx_pkg::ST_SA: begin
				t_load  = 1'b1;
				state_d = lfx_pkg::ST_SD;
			end
			lfx_pkg::ST_SD: begin
				mac_op     = lfx_pkg::MAC_LOAD;
				trig_add90 = 1'b1;
				t_load     = 1'b1;
				state_d    = lfx_pkg::ST_CZ;
			end
			lfx_pkg::ST_CZ: begin
				mac_op     = lfx_pkg::MAC_LOAD;
				trig_ang   = plane_q;
				trig_add90 = 1'b1;
				t_load     = 1'b1;
				state_d    = lfx_pkg::ST_XL;
			end
			lfx_pkg::ST_XL: begin
				mac_op  = lfx_pkg::MAC_LOAD;
				mac_b   = MW'(psd_q[15:0]);
				state_d = lfx_pkg::ST_XH;
			end
			lfx_pkg::ST_XH: begin
				mac_op   = lfx_pkg::MAC_ADDHI;
				mac_b    = MW'(psd_q[PSDW-1:16]);
				trig_ang = plane_q;
				t_load   = 1'b1;
				state_d  = lfx_pkg::ST_YL;
			end
			lfx_pkg::ST_YL: begin
				mac_op  = lfx_pkg::MAC_LOAD;
				mac_b   = MW'(psd_q[15:0]);
				state_d = lfx_pkg::ST_YH;
			end
			lfx_pkg::ST_YH: begin
				mac_op  = lfx_pkg::MAC_ADDHI;
				mac_b   = MW'(psd_q[PSDW-1:16]);
				state_d = lfx_pkg::ST_OUT;
			end
			lfx_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = lfx_pkg::ST_IDLE;
				end
			end
			default: state_d = lfx_pkg::ST_IDLE;
		endcase
	end

	// round to nearest, ties away from zero, then apply sign
	always_comb begin
		is_z    = (state_q == lfx_pkg::ST_XL);
		rnd_sum = acc + (is_z ? HALF_F : HALF_2F);
		rnd_mag = is_z ? 17'(rnd_sum >> F) : 17'(rnd_sum >> (2 * F));
		rnd_val = neg_q ? 17'(-rnd_mag) : rnd_mag;
	end

	always_comb begin
		cnt_next   = {1'b0, pcnt_q} + 17'd1;
		pend       = (cnt_next >= {1'b0, ppp_q});
		plane_next = {1'b0, plane_q} + {1'b0, rot_q};
		send       = pend && (plane_next >= 10'(lfx_pkg::FULL_TURN));
	end

	always_ff @(posedge clk) begin
		if (take && rec.match) begin
			dist_q   <= rec.dist_cm;
			ang_q    <= rec.ang;
			resync_q <= rec.resync;
		end
		if (t_load) begin
			t_mag_q <= trig_mag;
			t_neg_q <= trig_neg;
		end
		case (state_q)
			lfx_pkg::ST_SD: sa_neg_q <= t_neg_q;
			lfx_pkg::ST_CZ: begin
				psd_q <= acc[PSDW-1:0];
				neg_q <= t_neg_q;
			end
			lfx_pkg::ST_XL: begin
				z_q   <= rnd_val;
				neg_q <= t_neg_q ^ sa_neg_q;
			end
			lfx_pkg::ST_YL: begin
				x_q   <= rnd_val;
				neg_q <= t_neg_q ^ sa_neg_q;
			end
			default: ;
		endcase
		if (out_load) begin
			x_cm      <= x_q;
			y_cm      <= rnd_val;
			z_cm      <= z_q;
			plane_deg <= plane_q;
			resynced  <= resync_q;
			plane_end <= pend;
			scan_end  <= send;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q       <= lfx_pkg::ROT_RESET;
			ppp_q       <= lfx_pkg::PPP_RESET;
			pcnt_q      <= '0;
			plane_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lfx_pkg::CFG_ROTATE_STEP: rot_q <= cfg_data[8:0];
					lfx_pkg::CFG_POINTS:      ppp_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (pend) begin
					pcnt_q  <= '0;
					plane_q <= send ? 9'd0 : plane_next[8:0];
				end else begin
					pcnt_q <= cnt_next[15:0];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_match_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && rec.match) |=> (state_q == lfx_pkg::ST_SA))
		else $error("valid record did not start the point sequence");

	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		plane_q < 9'(lfx_pkg::FULL_TURN))
		else $error("plane angle out of range");

	a_scan_in_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!scan_end || plane_end))
		else $error("scan end without plane end");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == lfx_pkg::ST_OUT))
		else $error("output item raised outside the output step");

endmodule
